### rtl/core/hcfr_pkg.sv
// Shared constants, register codes and controller/datapath interface types
// for the header/checksum frame receiver. No dependencies.
`timescale 1ns / 1ps

package hcfr_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int RING_DEPTH  = MAX_PAYLOAD + 3;
    localparam int ADDR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W       = $clog2(RING_DEPTH + 1);
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 6;
    localparam int IDX_W       = 5;
    localparam int CFG_IDX_W   = 2;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hFF;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'hFE;
    localparam logic [LEN_W-1:0]  PAYLOAD_LEN_RST   = 6'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_FIRST   = 2'd0,
        CFG_HEADER_SECOND  = 2'd1,
        CFG_PAYLOAD_LENGTH = 2'd2
    } cfg_reg_t;

    // controller -> datapath
    typedef struct packed {
        logic cfg_wr;
        logic wr_byte;
        logic scan_start;
        logic scan_issue;
        logic offset_next;
        logic emit_start;
        logic emit_issue;
        logic emit_load;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic will_fill;
        logic pos_last;
        logic match;
        logic base_last;
        logic emit_last;
        logic out_free;
    } dp_stat_t;

endpackage

### rtl/core/hcfr_ctrl.sv
// Sequencer for the frame receiver: idle/write, offset scan, evaluate, emit.
// Depends on hcfr_pkg for command and status types.
`timescale 1ns / 1ps

module hcfr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              cfg_valid,
    input  hcfr_pkg::dp_stat_t stat,
    output hcfr_pkg::ctrl_cmd_t cmd,
    output logic              idle
);
    import hcfr_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_SCAN      = 5'b00010,
        ST_EVAL      = 5'b00100,
        ST_EMIT_RD   = 5'b01000,
        ST_EMIT_WAIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign idle = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.cfg_wr = cfg_valid;
                if (in_valid)
                begin
                    cmd.wr_byte = 1'b1;
                    if (stat.will_fill)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (stat.pos_last)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (stat.match)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = ST_EMIT_RD;
                end
                else if (stat.base_last)
                    state_next = ST_IDLE;
                else
                begin
                    cmd.offset_next = 1'b1;
                    state_next      = ST_SCAN;
                end
            end
            ST_EMIT_RD:
            begin
                cmd.emit_issue = 1'b1;
                state_next     = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = stat.emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/core/hcfr_dp.sv
// Datapath: byte ring memory, config registers, scan accumulators and output word register.
// Depends on hcfr_pkg; driven by hcfr_ctrl commands.
`timescale 1ns / 1ps

module hcfr_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  hcfr_pkg::ctrl_cmd_t                   cmd,
    output hcfr_pkg::dp_stat_t                    stat,
    input  logic [hcfr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hcfr_pkg::BYTE_W-1:0]           cfg_data,
    input  logic [hcfr_pkg::BYTE_W-1:0]           rx_byte,
    input  logic                                  out_stall,
    output logic                                  out_valid,
    output logic [hcfr_pkg::BYTE_W-1:0]           payload_byte,
    output logic [hcfr_pkg::IDX_W-1:0]            byte_index,
    output logic                                  last
);
    import hcfr_pkg::*;

    logic [BYTE_W-1:0] ring [RING_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    logic [BYTE_W-1:0] hf_reg;
    logic [BYTE_W-1:0] hs_reg;
    logic [LEN_W-1:0]  plen_reg;
    logic [ADDR_W-1:0] wr_ptr_reg;
    logic [ADDR_W-1:0] wr_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] pos_reg;
    logic [ADDR_W-1:0] dpos_reg;
    logic              dvalid_reg;
    logic              hdr_ok_reg;
    logic [BYTE_W-1:0] sum_reg;
    logic [LEN_W-1:0]  j_reg;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] payload_byte_reg;
    logic [IDX_W-1:0]  byte_index_reg;
    logic              last_reg;

    logic [LEN_W-1:0]  len;
    logic [CNT_W-1:0]  size;
    logic [ADDR_W-1:0] ptr_eff;
    logic [ADDR_W-1:0] base_inc;

    function automatic logic [ADDR_W-1:0] inc_wrap(input logic [ADDR_W-1:0] a,
                                                   input logic [CNT_W-1:0]  s);
        logic [CNT_W-1:0] n;
        n = CNT_W'(a) + CNT_W'(1);
        inc_wrap = (n >= s) ? '0 : ADDR_W'(n);
    endfunction

    // effective length: 0 acts as 1, above the maximum clamps
    always_comb
    begin
        priority if (plen_reg == '0)
            len = LEN_W'(1);
        else if (plen_reg > LEN_W'(MAX_PAYLOAD))
            len = LEN_W'(MAX_PAYLOAD);
        else
            len = plen_reg;
    end

    assign size     = CNT_W'(len) + CNT_W'(3);
    assign ptr_eff  = (CNT_W'(wr_ptr_reg) < size) ? wr_ptr_reg : '0;
    assign base_inc = inc_wrap(base_reg, size);

    assign stat.will_fill = (count_reg >= size - CNT_W'(1));
    assign stat.pos_last  = (CNT_W'(pos_reg) == size - CNT_W'(1));
    assign stat.base_last = (CNT_W'(base_reg) == size - CNT_W'(1));
    assign stat.match     = hdr_ok_reg && (sum_reg == rd_data_reg);
    assign stat.emit_last = (j_reg == len - LEN_W'(1));
    assign stat.out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (cmd.wr_byte)
        begin
            wr_ptr_next = inc_wrap(ptr_eff, size);
            if (count_reg < size)
                count_next = count_reg + CNT_W'(1);
        end
        if (cmd.emit_start)
            count_next = '0;
        if (cmd.cfg_wr && (cfg_index == CFG_PAYLOAD_LENGTH))
        begin
            wr_ptr_next = '0;
            count_next  = '0;
        end
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_byte)
            ring[ptr_eff] <= rx_byte;
        if (cmd.scan_issue || cmd.emit_issue)
            rd_data_reg <= ring[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hf_reg        <= HEADER_FIRST_RST;
            hs_reg        <= HEADER_SECOND_RST;
            plen_reg      <= PAYLOAD_LEN_RST;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            dvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            dvalid_reg <= cmd.scan_issue;
            if (cmd.cfg_wr)
            begin
                case (cfg_index)
                    CFG_HEADER_FIRST:   hf_reg   <= cfg_data;
                    CFG_HEADER_SECOND:  hs_reg   <= cfg_data;
                    CFG_PAYLOAD_LENGTH: plen_reg <= cfg_data[LEN_W-1:0];
                    default:            ;
                endcase
            end
            if (cmd.emit_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // scan addressing and accumulation
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            base_reg <= '0;
            addr_reg <= '0;
            pos_reg  <= '0;
        end
        else if (cmd.scan_issue)
        begin
            addr_reg <= inc_wrap(addr_reg, size);
            pos_reg  <= pos_reg + ADDR_W'(1);
        end
        else if (cmd.offset_next)
        begin
            base_reg <= base_inc;
            addr_reg <= base_inc;
            pos_reg  <= '0;
        end
        else if (cmd.emit_start)
            addr_reg <= inc_wrap(base_inc, size);
        else if (cmd.emit_issue)
            addr_reg <= inc_wrap(addr_reg, size);

        if (cmd.scan_issue)
            dpos_reg <= pos_reg;

        if (dvalid_reg)
        begin
            if (dpos_reg == '0)
            begin
                hdr_ok_reg <= (rd_data_reg == hf_reg);
                sum_reg    <= '0;
            end
            else if (dpos_reg == ADDR_W'(1))
                hdr_ok_reg <= hdr_ok_reg && (rd_data_reg == hs_reg);
            else if (CNT_W'(dpos_reg) < CNT_W'(len) + CNT_W'(2))
                sum_reg <= sum_reg + rd_data_reg;
        end

        if (cmd.emit_start)
            j_reg <= '0;
        else if (cmd.emit_load)
            j_reg <= j_reg + LEN_W'(1);

        if (cmd.emit_load)
        begin
            payload_byte_reg <= rd_data_reg;
            byte_index_reg   <= j_reg[IDX_W-1:0];
            last_reg         <= stat.emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign payload_byte = payload_byte_reg;
    assign byte_index   = byte_index_reg;
    assign last         = last_reg;

endmodule

### rtl/core/header_checksum_frame_receiver.sv
// Operation: a byte that completes a ring of S = L+3 bytes starts a scan of S offsets,
//   bounded by the single ring read port; a match then emits the payload words, each
//   read, then loaded once the output word is free; any other byte is just stored.
// Throughput: one byte at a time; in_stall is high through scan and emit.
// Reset (rst_n, async low): pointer and count cleared, headers FF/FE, length 8;
//   ring contents undefined until written.
`timescale 1ns / 1ps

// Top level: serial-byte frame receiver with two-byte sync header and
// modulo-256 payload checksum. Depends on hcfr_pkg, hcfr_ctrl, hcfr_dp.
module header_checksum_frame_receiver (
    input  logic                               clk,
    input  logic                               rst_n,
    // received byte words
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [hcfr_pkg::BYTE_W-1:0]        rx_byte,
    // payload words of validated frames
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [hcfr_pkg::BYTE_W-1:0]        payload_byte,
    output logic [hcfr_pkg::IDX_W-1:0]         byte_index,
    output logic                               last,
    // register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hcfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hcfr_pkg::BYTE_W-1:0]        cfg_data
);
    import hcfr_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;
    logic      idle;

    // Input and register writes are only taken while the sequencer idles.
    assign in_stall  = !idle;
    assign cfg_ready = idle;

    // Sequencer: per offset, S reads stream out of the ring (one per cycle), then an
    // evaluate state checks the header and compares the running sum against the checksum.
    hcfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cfg_valid (cfg_valid),
        .stat      (stat),
        .cmd       (cmd),
        .idle      (idle)
    );

    // Datapath: ring memory, header match, payload sum, output word register.
    hcfr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rx_byte      (rx_byte),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .last         (last)
    );

endmodule

### rtl/core/hcfr_checker.sv
// Port-level assertions for the frame receiver, bound to the top level.
// Depends on hcfr_pkg for widths.
`timescale 1ns / 1ps

module hcfr_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic [hcfr_pkg::BYTE_W-1:0]        payload_byte,
    input logic [hcfr_pkg::IDX_W-1:0]         byte_index,
    input logic                               last,
    input logic                               cfg_ready
);
    import hcfr_pkg::*;

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(payload_byte)
            && $stable(byte_index) && $stable(last))
        else $error("output word changed while stalled");

    // register port and byte input open together
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready == !in_stall)
        else $error("cfg_ready and in_stall disagree");

    // a new output word only appears while the block is busy emitting
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("output word appeared outside emit");

    // a non-final word cannot sit at the top index
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> byte_index != {IDX_W{1'b1}})
        else $error("non-final word at top index");

endmodule

bind header_checksum_frame_receiver hcfr_checker u_hcfr_checker (.*);
